>>> sv/fsda_pkg.sv
// ----------------------------------------------------------------------------
// fsda_pkg: shared definitions for the fp16 skinny dot-accumulate block
// Sizes, register indexes, fp16 constants and the item types that travel
// between the channel interfaces, the lane accumulators and the reduction.
// ----------------------------------------------------------------------------
package fsda_pkg;

  // Lane accumulators per column and the number of B columns kept.
  localparam int ACC_LANES = 8;
  localparam int MAX_COLS  = 3;
  localparam int NCOL      = (MAX_COLS < 3) ? MAX_COLS : 3;

  // Lane index width and number of pairwise reduction levels.
  localparam int LIW = (ACC_LANES > 1) ? $clog2(ACC_LANES) : 1;
  localparam int NLV = $clog2(ACC_LANES);

  // Pipeline depth of one fused multiply-add unit.
  localparam int FMA_LAT = 5;

  // Configuration port.
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_BETA = 2'd0;
  localparam logic [CFG_IW-1:0] REG_COLS = 2'd1;
  localparam logic [15:0] BETA_RST = 16'h3C00;
  localparam logic [1:0]  COLS_RST = 2'd1;

  // fp16 bit patterns.
  localparam logic [15:0] HALF_ONE   = 16'h3C00;
  localparam logic [15:0] HALF_NZERO = 16'h8000;
  localparam logic [15:0] HALF_PZERO = 16'h0000;
  localparam logic [15:0] HALF_QNAN  = 16'h7E00;
  localparam logic [14:0] HALF_INF   = 15'h7C00;

  typedef struct packed {
    logic [15:0] a_value;
    logic [15:0] b_col0;
    logic [15:0] b_col1;
    logic [15:0] b_col2;
    logic [15:0] c_in0;
    logic [15:0] c_in1;
    logic [15:0] c_in2;
    logic        last_element;
  } in_item_t;

  typedef struct packed {
    logic [15:0] c_out0;
    logic [15:0] c_out1;
    logic [15:0] c_out2;
  } out_item_t;

  // Final lane values of one row, handed from the lanes to the reduction.
  typedef struct packed {
    logic                                valid;
    logic [NCOL-1:0]                     colmask;
    logic [NCOL-1:0][15:0]               c_in;
    logic [15:0]                         beta;
    logic [NCOL-1:0][ACC_LANES-1:0][15:0] lanes;
  } snap_t;

  // Number of values left after l pairwise levels.
  function automatic int lvl_n(input int l);
    int n;
    n = ACC_LANES;
    for (int s = 0; s < l; s++) begin
      n = (n + 1) / 2;
    end
    return n;
  endfunction

endpackage

>>> sv/fsda_stream_if.sv
// ----------------------------------------------------------------------------
// fsda_stream_if: valid/ready channels of the dot-accumulate block
// One interface for the element stream and one for the result stream.
// ----------------------------------------------------------------------------
interface fsda_in_if;
  import fsda_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fsda_out_if;
  import fsda_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/fsda_fma.sv
// ----------------------------------------------------------------------------
// fsda_fma: pipelined fp16 fused multiply-add, res = c + a*b
// Exact sum on a fixed-point grid, then one round to nearest even.
// Five register stages; every stage advances only when en_i is high.
// ----------------------------------------------------------------------------
module fsda_fma (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] c_i,
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  output logic [15:0] res_o
);
  import fsda_pkg::*;

  typedef struct packed {
    logic nan;
    logic inf;
    logic isign;
    logic zsign;
  } fl_t;

  // Stage 1: unpack, multiply significands, classify special operands.
  logic [10:0] ma, mb, mc;
  logic [4:0]  sha, shb, shc5;
  logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero;
  logic        sp, pinf;
  fl_t         fl1;

  always_comb begin
    ma     = {|a_i[14:10], a_i[9:0]};
    mb     = {|b_i[14:10], b_i[9:0]};
    mc     = {|c_i[14:10], c_i[9:0]};
    sha    = (a_i[14:10] == 5'd0) ? 5'd0 : a_i[14:10] - 5'd1;
    shb    = (b_i[14:10] == 5'd0) ? 5'd0 : b_i[14:10] - 5'd1;
    shc5   = (c_i[14:10] == 5'd0) ? 5'd0 : c_i[14:10] - 5'd1;
    a_nan  = (&a_i[14:10]) & (|a_i[9:0]);
    b_nan  = (&b_i[14:10]) & (|b_i[9:0]);
    c_nan  = (&c_i[14:10]) & (|c_i[9:0]);
    a_inf  = (&a_i[14:10]) & ~(|a_i[9:0]);
    b_inf  = (&b_i[14:10]) & ~(|b_i[9:0]);
    c_inf  = (&c_i[14:10]) & ~(|c_i[9:0]);
    a_zero = ~(|a_i[14:0]);
    b_zero = ~(|b_i[14:0]);
    sp     = a_i[15] ^ b_i[15];
    pinf   = a_inf | b_inf;
    fl1.nan   = a_nan | b_nan | c_nan | (pinf & (a_zero | b_zero)) |
                (pinf & c_inf & (sp != c_i[15]));
    fl1.inf   = pinf | c_inf;
    fl1.isign = pinf ? sp : c_i[15];
    // Sign of an exact zero: negative only when both terms are negative zero.
    fl1.zsign = sp & c_i[15];
  end

  logic [21:0] prod_q;
  logic [5:0]  shp_q, shc_q;
  logic [10:0] mc_q;
  logic        sp_q, sc_q;
  fl_t         fl1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ma * mb;
      shp_q  <= 6'(sha) + 6'(shb);
      shc_q  <= 6'(shc5) + 6'd24;
      mc_q   <= mc;
      sp_q   <= sp;
      sc_q   <= c_i[15];
      fl1_q  <= fl1;
    end
  end

  // Stage 2: align both terms on a 2^-48 grid and add in two's complement.
  logic [80:0] p_al, c_al;
  logic [81:0] p_t, c_t;

  always_comb begin
    p_al = {59'd0, prod_q} << shp_q;
    c_al = {70'd0, mc_q} << shc_q;
    p_t  = sp_q ? (~{1'b0, p_al} + 82'd1) : {1'b0, p_al};
    c_t  = sc_q ? (~{1'b0, c_al} + 82'd1) : {1'b0, c_al};
  end

  logic [81:0] sum_q;
  fl_t         fl2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= p_t + c_t;
      fl2_q <= fl1_q;
    end
  end

  // Stage 3: sign and magnitude.
  logic [81:0] abs_v;

  always_comb begin
    abs_v = sum_q[81] ? (~sum_q + 82'd1) : sum_q;
  end

  logic [80:0] mag_q;
  logic        sgn_q;
  fl_t         fl3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= abs_v[80:0];
      sgn_q <= sum_q[81];
      fl3_q <= fl2_q;
    end
  end

  // Stage 4: leading one position.
  logic [6:0] pos;

  always_comb begin
    pos = 7'd0;
    for (int i = 0; i < 81; i++) begin
      if (mag_q[i]) begin
        pos = 7'(i);
      end
    end
  end

  logic [80:0] mag4_q;
  logic [6:0]  pos_q;
  logic        nz_q, sgn4_q;
  fl_t         fl4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag4_q <= mag_q;
      pos_q  <= pos;
      nz_q   <= |mag_q;
      sgn4_q <= sgn_q;
      fl4_q  <= fl3_q;
    end
  end

  // Stage 5: normalize, round to nearest even, pack.
  logic [6:0]  pm, ls, base;
  logic [80:0] nrm;
  logic [10:0] rsig;
  logic        rup;
  logic [16:0] tot;
  logic        ovf;
  logic [15:0] res_d;

  always_comb begin
    pm   = (pos_q < 7'd34) ? 7'd34 : pos_q;
    ls   = 7'd80 - pm;
    base = pm - 7'd34;
    nrm  = mag4_q << ls;
    rsig = nrm[80:70];
    rup  = nrm[69] & ((|nrm[68:0]) | rsig[0]);
    tot  = {base[6:0], 10'd0} + 17'(rsig) + 17'(rup);
    ovf  = (pos_q > 7'd63) || (tot >= 17'h07C00);
    if (fl4_q.nan) begin
      res_d = HALF_QNAN;
    end else if (fl4_q.inf) begin
      res_d = {fl4_q.isign, HALF_INF};
    end else if (!nz_q) begin
      res_d = {fl4_q.zsign, 15'd0};
    end else if (ovf) begin
      res_d = {sgn4_q, HALF_INF};
    end else begin
      res_d = {sgn4_q, tot[14:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end

endmodule

>>> sv/fsda_lanes.sv
// ----------------------------------------------------------------------------
// fsda_lanes: rotating lane accumulators, one FMA unit per column
// Each transfer updates one lane of every column in use. On the last element
// the final lane values of the row are handed to the reduction.
// ----------------------------------------------------------------------------
module fsda_lanes (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        issue_i,
  input  fsda_pkg::in_item_t          item_i,
  input  logic [fsda_pkg::NCOL-1:0]   colmask_i,
  input  logic [15:0]                 beta_i,
  output logic                        hazard_o,
  output fsda_pkg::snap_t             snap_o
);
  import fsda_pkg::*;

  typedef struct packed {
    logic                            valid;
    logic                            last;
    logic [LIW-1:0]                  lane;
    logic [NCOL-1:0]                 colmask;
    logic [NCOL-1:0][ACC_LANES-1:0]  flags;
    logic [NCOL-1:0][15:0]           c_in;
    logic [15:0]                     beta;
  } lpipe_t;

  logic [LIW-1:0]                 lane_q, lane_d;
  logic [NCOL-1:0][ACC_LANES-1:0] flags_q, flags_d, flags_set;
  logic [15:0]                    sums_q [NCOL][ACC_LANES];
  lpipe_t                         pipe_q [FMA_LAT];
  lpipe_t                         tail;
  logic [15:0]                    b_v [3];
  logic [15:0]                    c_v [3];
  logic [15:0]                    acc_c [NCOL];
  logic [15:0]                    fma_res [NCOL];

  assign b_v[0] = item_i.b_col0;
  assign b_v[1] = item_i.b_col1;
  assign b_v[2] = item_i.b_col2;
  assign c_v[0] = item_i.c_in0;
  assign c_v[1] = item_i.c_in1;
  assign c_v[2] = item_i.c_in2;
  assign tail   = pipe_q[FMA_LAT-1];

  // A lane not yet touched in this row reads as positive zero.
  always_comb begin
    for (int k = 0; k < NCOL; k++) begin
      acc_c[k] = flags_q[k][lane_q] ? sums_q[k][lane_q] : HALF_PZERO;
    end
  end

  for (genvar k = 0; k < NCOL; k++) begin : g_col
    fsda_fma u_fma (
      .clk_i (clk_i),
      .en_i  (en_i),
      .c_i   (acc_c[k]),
      .a_i   (item_i.a_value),
      .b_i   (b_v[k]),
      .res_o (fma_res[k])
    );
  end

  // Lane pointer and touched flags for the row in progress.
  always_comb begin
    flags_set = flags_q;
    for (int k = 0; k < NCOL; k++) begin
      if (colmask_i[k]) begin
        flags_set[k][lane_q] = 1'b1;
      end
    end
    flags_d = flags_q;
    lane_d  = lane_q;
    if (issue_i) begin
      if (item_i.last_element) begin
        flags_d = '0;
        lane_d  = '0;
      end else begin
        flags_d = flags_set;
        lane_d  = (lane_q == LIW'(ACC_LANES - 1)) ? '0 : lane_q + LIW'(1);
      end
    end
  end

  // An update may not read a lane whose previous update is still in flight.
  always_comb begin
    logic any_flag, inflight;
    any_flag = 1'b0;
    inflight = 1'b0;
    for (int k = 0; k < NCOL; k++) begin
      any_flag = any_flag | flags_q[k][lane_q];
    end
    for (int s = 0; s < FMA_LAT; s++) begin
      inflight = inflight | (pipe_q[s].valid && (pipe_q[s].lane == lane_q));
    end
    hazard_o = any_flag & inflight;
  end

  // Side information that follows each update through the FMA pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q  <= '0;
      flags_q <= '0;
      for (int s = 0; s < FMA_LAT; s++) begin
        pipe_q[s] <= '0;
      end
    end else if (en_i) begin
      lane_q            <= lane_d;
      flags_q           <= flags_d;
      pipe_q[0].valid   <= issue_i;
      pipe_q[0].last    <= item_i.last_element;
      pipe_q[0].lane    <= lane_q;
      pipe_q[0].colmask <= colmask_i;
      pipe_q[0].flags   <= flags_set;
      pipe_q[0].beta    <= beta_i;
      for (int k = 0; k < NCOL; k++) begin
        pipe_q[0].c_in[k] <= c_v[k];
      end
      for (int s = 1; s < FMA_LAT; s++) begin
        pipe_q[s] <= pipe_q[s-1];
      end
    end
  end

  // Write back finished updates.
  always_ff @(posedge clk_i) begin
    if (en_i && tail.valid) begin
      for (int k = 0; k < NCOL; k++) begin
        if (tail.colmask[k]) begin
          sums_q[k][tail.lane] <= fma_res[k];
        end
      end
    end
  end

  // Row snapshot, including the write that lands in this cycle.
  always_comb begin
    snap_o.valid   = tail.valid & tail.last;
    snap_o.colmask = tail.colmask;
    snap_o.c_in    = tail.c_in;
    snap_o.beta    = tail.beta;
    for (int k = 0; k < NCOL; k++) begin
      for (int j = 0; j < ACC_LANES; j++) begin
        if (!tail.flags[k][j]) begin
          snap_o.lanes[k][j] = HALF_PZERO;
        end else if (tail.colmask[k] && (tail.lane == LIW'(j))) begin
          snap_o.lanes[k][j] = fma_res[k];
        end else begin
          snap_o.lanes[k][j] = sums_q[k][j];
        end
      end
    end
  end

  a_no_issue_on_hazard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_i |-> !hazard_o)
    else $error("lane update issued over a pending update");

  a_row_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue_i && item_i.last_element) |=> (flags_q == '0) && (lane_q == '0))
    else $error("lanes not cleared after the last element");

  a_col0_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue_i && !item_i.last_element) |=> flags_q[0][$past(lane_q)])
    else $error("column zero lane not marked after an update");

endmodule

>>> sv/fsda_reduce.sv
// ----------------------------------------------------------------------------
// fsda_reduce: pairwise lane reduction, beta scaling and final add
// Adjacent lanes are added level by level, an odd last lane passes through.
// Then c_in*beta is formed and added to the dot product of each column.
// ----------------------------------------------------------------------------
module fsda_reduce (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  fsda_pkg::snap_t     snap_i,
  output logic                res_valid_o,
  output fsda_pkg::out_item_t res_o
);
  import fsda_pkg::*;

  localparam int DEPTH = (NLV + 2) * FMA_LAT;

  typedef struct packed {
    logic                  valid;
    logic [NCOL-1:0]       colmask;
    logic [NCOL-1:0][15:0] c_in;
    logic [15:0]           beta;
  } side_t;

  side_t       side_q [DEPTH+1];
  logic [15:0] lv0_q [NCOL][ACC_LANES];
  logic [15:0] lv [NLV+1][NCOL][ACC_LANES];
  logic [15:0] prod [NCOL];
  logic [15:0] fin [NCOL];
  logic [15:0] dly_q [NCOL][FMA_LAT];
  side_t       scale_side;
  side_t       out_side;

  assign scale_side = side_q[NLV*FMA_LAT];
  assign out_side   = side_q[DEPTH];

  // Control travels alongside the arithmetic.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= DEPTH; s++) begin
        side_q[s] <= '0;
      end
    end else if (en_i) begin
      side_q[0].valid   <= snap_i.valid;
      side_q[0].colmask <= snap_i.colmask;
      side_q[0].c_in    <= snap_i.c_in;
      side_q[0].beta    <= snap_i.beta;
      for (int s = 1; s <= DEPTH; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // Capture the final lane values of the row.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NCOL; k++) begin
        for (int j = 0; j < ACC_LANES; j++) begin
          lv0_q[k][j] <= snap_i.lanes[k][j];
        end
      end
    end
  end

  for (genvar k = 0; k < NCOL; k++) begin : g_lv0
    for (genvar j = 0; j < ACC_LANES; j++) begin : g_lane
      assign lv[0][k][j] = lv0_q[k][j];
    end
  end

  // Reduction levels.
  for (genvar l = 0; l < NLV; l++) begin : g_lvl
    for (genvar k = 0; k < NCOL; k++) begin : g_col
      for (genvar i = 0; i < ACC_LANES; i++) begin : g_node
        if (i >= lvl_n(l + 1)) begin : g_unused
          assign lv[l+1][k][i] = HALF_PZERO;
        end else if (2 * i + 1 < lvl_n(l)) begin : g_add
          fsda_fma u_add (
            .clk_i (clk_i),
            .en_i  (en_i),
            .c_i   (lv[l][k][2*i]),
            .a_i   (lv[l][k][2*i+1]),
            .b_i   (HALF_ONE),
            .res_o (lv[l+1][k][i])
          );
        end else begin : g_pass
          logic [15:0] pass_q [FMA_LAT];
          always_ff @(posedge clk_i) begin
            if (en_i) begin
              pass_q[0] <= lv[l][k][2*i];
              for (int s = 1; s < FMA_LAT; s++) begin
                pass_q[s] <= pass_q[s-1];
              end
            end
          end
          assign lv[l+1][k][i] = pass_q[FMA_LAT-1];
        end
      end
    end
  end

  // Scale the old C value and add the dot product.
  for (genvar k = 0; k < NCOL; k++) begin : g_fin
    fsda_fma u_mul (
      .clk_i (clk_i),
      .en_i  (en_i),
      .c_i   (HALF_NZERO),
      .a_i   (scale_side.c_in[k]),
      .b_i   (scale_side.beta),
      .res_o (prod[k])
    );

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dly_q[k][0] <= lv[NLV][k][0];
        for (int s = 1; s < FMA_LAT; s++) begin
          dly_q[k][s] <= dly_q[k][s-1];
        end
      end
    end

    fsda_fma u_sum (
      .clk_i (clk_i),
      .en_i  (en_i),
      .c_i   (prod[k]),
      .a_i   (dly_q[k][FMA_LAT-1]),
      .b_i   (HALF_ONE),
      .res_o (fin[k])
    );
  end

  // Columns not in use report zero.
  always_comb begin
    logic [15:0] col_v [3];
    for (int k = 0; k < 3; k++) begin
      col_v[k] = HALF_PZERO;
    end
    for (int k = 0; k < NCOL; k++) begin
      col_v[k] = out_side.colmask[k] ? fin[k] : HALF_PZERO;
    end
    res_valid_o  = out_side.valid;
    res_o.c_out0 = col_v[0];
    res_o.c_out1 = col_v[1];
    res_o.c_out2 = col_v[2];
  end

endmodule

>>> sv/fp16_skinny_dot_accumulate_top.sv
// ----------------------------------------------------------------------------
// fp16_skinny_dot_accumulate_top: fp16 row-times-columns dot accumulate
// Streams one A row element and up to three B elements per transfer and
// returns c_in*beta + dot for each column after the last element of a row.
//
//   Channel   Dir  Handshake      Payload
//   in_i      in   valid/ready    a_value, b_col0..2, c_in0..2, last_element
//   out_o     out  valid/ready    c_out0..2
//   cfg       in   cfg_we_i       cfg_idx_i (0 beta, 1 column_count), cfg_data_i
//
// One element transfer per cycle is accepted unless the datapath stalls; a lane
// update runs in its column's FMA unit, and eight rotating lanes per column
// keep it out of the way. A row then passes, in order, through the lane update,
// the snapshot register, log2(lanes) reduction levels, the beta multiply, the
// final add and the output register before its result is offered.
// Reset is asynchronous and active low and clears all control.
// Input is held back only while a result waits at the pipeline tail and the
// output register is full and not taken.
// ----------------------------------------------------------------------------
module fp16_skinny_dot_accumulate_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  fsda_in_if.sink                     in_i,
  fsda_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [fsda_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [15:0]                 cfg_data_i
);
  import fsda_pkg::*;

  logic [15:0]     beta_q;
  logic [1:0]      cols_q;
  logic [1:0]      n_cols;
  logic [NCOL-1:0] colmask;
  logic            pipe_en, hazard, in_ready, accept;
  logic            res_valid;
  out_item_t       res;
  snap_t           snap;
  logic            out_valid_q;
  out_item_t       out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= BETA_RST;
      cols_q <= COLS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BETA: beta_q <= cfg_data_i;
        REG_COLS: cols_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Columns in use: zero counts as one, clamp at the columns kept.
  always_comb begin
    n_cols = (cols_q == 2'd0) ? 2'd1 : cols_q;
    if (n_cols > 2'(NCOL)) begin
      n_cols = 2'(NCOL);
    end
    for (int k = 0; k < NCOL; k++) begin
      colmask[k] = 2'(k) < n_cols;
    end
  end

  // The datapath advances unless a result is blocked at the tail.
  assign pipe_en  = !(res_valid && out_valid_q && !out_o.ready);
  assign in_ready = pipe_en && !hazard;
  assign accept   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  fsda_lanes u_lanes (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (pipe_en),
    .issue_i   (accept),
    .item_i    (in_i.data),
    .colmask_i (colmask),
    .beta_i    (beta_q),
    .hazard_o  (hazard),
    .snap_o    (snap)
  );

  fsda_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .snap_i      (snap),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |-> (res_valid && out_valid_q && !out_o.ready))
    else $error("datapath stalled without a blocked result");

  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> pipe_en)
    else $error("element transfer while the datapath is stalled");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_en && res_valid) |=> out_valid_q)
    else $error("finished result not held in the output register");

endmodule
